// File: rtl/tcbl_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and reset constants of the token bucket limiter
package tcbl_pkg;

   // field and register widths
   localparam int LEVEL_W    = 24;
   localparam int CAP_W      = 8;
   localparam int REFILL_W   = 20;
   localparam int WAIT_W     = 17;
   localparam int CLASS_W    = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   // bucket storage and class limits
   localparam int REG_CLASSES = 3;
   localparam int NUM_CLASSES = 3;
   localparam int FRACTION_BITS_DEFAULT = 16;

   // saturation values
   localparam logic [WAIT_W-1:0]  WAIT_MAX  = '1;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

   // reset capacities (whole tokens) and refills (fraction units)
   localparam logic [CAP_W-1:0] CAP_RESET [REG_CLASSES] = '{8'd10, 8'd20, 8'd20};
   localparam logic [REFILL_W-1:0] REFILL_RESET [REG_CLASSES] =
      '{20'd655, 20'd1311, 20'd1311};

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ORDER_CAPACITY  = 3'd0,
      REG_QUERY_CAPACITY  = 3'd1,
      REG_PUBLIC_CAPACITY = 3'd2,
      REG_ORDER_REFILL    = 3'd3,
      REG_QUERY_REFILL    = 3'd4,
      REG_PUBLIC_REFILL   = 3'd5
   } csr_index_type;

   // item kinds carried in tuser
   localparam logic ACTION_TICK    = 1'b0;
   localparam logic ACTION_REQUEST = 1'b1;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic tick_apply;
      logic grant_apply;
      logic div_start;
      logic div_step;
      logic load_out;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_tick;
      logic class_ok;
      logic has_token;
      logic out_free;
   } status_type;

endpackage

// File: rtl/three_class_token_bucket_limiter_core.sv
`timescale 1ns / 1ps
// Three-class token bucket limiter: one fixed-point token level per class
// (order, query, public) with FRACTION_BITS fraction bits. A tick beat refills
// every bucket and clamps it at its capacity and gives no result; a request
// beat takes one token from its class and answers granted, or refused with
// the ticks to wait, ceil((1 - level) / refill). Requests naming a class
// outside the bucket set give no result. One beat is handled at a time: a tick
// is applied in the evaluation state, a grant goes on to the result state, and
// a refusal first runs the restoring divider, one quotient bit per cycle. The
// next beat is taken while a result waits in the output register. The configuration
// port is always ready and must be written only while idle; the block does not enforce this.
module three_class_token_bucket_limiter_core #(
   parameter int FRACTION_BITS = tcbl_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request beats
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,   // [0] action
   input  logic [tcbl_pkg::REQ_DATA_W-1:0]   req_tdata,   // [1:0] traffic_class
   // result beats
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic                              rsp_tuser,   // [0] granted
   output logic [tcbl_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [16:0] wait_ticks, [40:17] level_after
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tcbl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tcbl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tcbl_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // sequencer
   tcbl_ctrl #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // buckets, registers, divider and output stage
   tcbl_datapath #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/tcbl_ctrl.sv
`timescale 1ns / 1ps
// controller state machine sequencing ticks, grants and the wait divider
module tcbl_ctrl #(
   parameter int FRACTION_BITS = tcbl_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  tcbl_pkg::status_type   status,
   output tcbl_pkg::cmd_type      cmd
);
   import tcbl_pkg::*;

   // divider runs one quotient bit per cycle over the numerator width
   localparam int NUM_W = FRACTION_BITS + 1;
   localparam int CNT_W = $clog2(NUM_W);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              div_last;

   assign div_last = (count_ff == CNT_W'(NUM_W - 1));

   // state and step counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.is_tick || !status.class_ok) state_in = ST_IDLE;
            else if (status.has_token)               state_in = ST_RESULT;
            else                                     state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_last) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and counter
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      count_in   = count_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_EVAL: begin
            count_in = '0;
            if (status.is_tick) begin
               cmd.tick_apply = 1'b1;
            end else if (status.class_ok) begin
               cmd.grant_apply = status.has_token;
               cmd.div_start   = !status.has_token;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + CNT_W'(1);
         end
         ST_RESULT: begin
            cmd.load_out = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: rtl/tcbl_datapath.sv
`timescale 1ns / 1ps
// bucket levels, configuration registers, wait divider and result register
module tcbl_datapath #(
   parameter int FRACTION_BITS = tcbl_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcbl_pkg::cmd_type                 cmd,
   output tcbl_pkg::status_type              status,
   input  logic                              req_tuser,
   input  logic [tcbl_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              csr_valid,
   input  logic [tcbl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tcbl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic                              rsp_tuser,
   output logic [tcbl_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import tcbl_pkg::*;

   localparam int NUM_W = FRACTION_BITS + 1;
   localparam logic [31:0] ONE = 32'd1 << FRACTION_BITS;

   // capacity in fixed point, saturated at the level width
   function automatic logic [LEVEL_W-1:0] ceiling_of(input logic [CAP_W-1:0] cap);
      logic [31:0] full;
      full = 32'(cap) << FRACTION_BITS;
      return (full > 32'(LEVEL_MAX)) ? LEVEL_MAX : full[LEVEL_W-1:0];
   endfunction

   logic                item_action_ff;
   logic [CLASS_W-1:0]  item_class_ff;
   logic [LEVEL_W-1:0]  level_ff [REG_CLASSES];
   logic [CAP_W-1:0]    cap_ff [REG_CLASSES];
   logic [REFILL_W-1:0] refill_ff [REG_CLASSES];
   logic                res_granted_ff;
   logic [LEVEL_W-1:0]  res_level_ff;
   logic [REFILL_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic [REFILL_W-1:0] div_ff;
   logic                out_valid_ff;
   logic                out_granted_ff;
   logic [WAIT_W-1:0]   out_wait_ff, out_wait_in;
   logic [LEVEL_W-1:0]  out_level_ff;

   logic [CLASS_W-1:0]  cls_idx;
   logic [LEVEL_W-1:0]  cur_level;
   logic [31:0]         numerator;
   logic [REFILL_W:0]   shifted;
   logic [31:0]         wait_full;

   // status toward the controller
   always_comb begin
      status.is_tick   = (item_action_ff == ACTION_TICK);
      status.class_ok  = (32'(item_class_ff) < REG_CLASSES) &&
                         (32'(item_class_ff) < NUM_CLASSES);
      cls_idx          = status.class_ok ? item_class_ff : '0;
      cur_level        = level_ff[cls_idx];
      status.has_token = (32'(cur_level) >= ONE);
      status.out_free  = !out_valid_ff || rsp_tready;
   end

   // missing fraction of one token, at most one token so it fits the numerator
   assign numerator = ONE - 32'(cur_level);

   // captured request beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_action_ff <= req_tuser;
         item_class_ff  <= req_tdata[CLASS_W-1:0];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_CLASSES; i++) begin
            cap_ff[i]    <= CAP_RESET[i];
            refill_ff[i] <= REFILL_RESET[i];
         end
      end else if (csr_valid) begin
         case (csr_index)
            REG_ORDER_CAPACITY:  cap_ff[0]    <= csr_wdata[CAP_W-1:0];
            REG_QUERY_CAPACITY:  cap_ff[1]    <= csr_wdata[CAP_W-1:0];
            REG_PUBLIC_CAPACITY: cap_ff[2]    <= csr_wdata[CAP_W-1:0];
            REG_ORDER_REFILL:    refill_ff[0] <= csr_wdata[REFILL_W-1:0];
            REG_QUERY_REFILL:    refill_ff[1] <= csr_wdata[REFILL_W-1:0];
            REG_PUBLIC_REFILL:   refill_ff[2] <= csr_wdata[REFILL_W-1:0];
            default: ;
         endcase
      end
   end

   // bucket levels: refill all on a tick, take one token on a grant
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_CLASSES; i++) begin
            level_ff[i] <= ceiling_of(CAP_RESET[i]);
         end
      end else if (cmd.tick_apply) begin
         for (int i = 0; i < REG_CLASSES; i++) begin
            if ((LEVEL_W + 1)'(level_ff[i]) + (LEVEL_W + 1)'(refill_ff[i]) >
                (LEVEL_W + 1)'(ceiling_of(cap_ff[i])))
               level_ff[i] <= ceiling_of(cap_ff[i]);
            else
               level_ff[i] <= level_ff[i] + LEVEL_W'(refill_ff[i]);
         end
      end else if (cmd.grant_apply) begin
         level_ff[cls_idx] <= cur_level - ONE[LEVEL_W-1:0];
      end
   end

   // restoring divider step, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      if (shifted >= {1'b0, div_ff}) begin
         rem_in = REFILL_W'(shifted - {1'b0, div_ff});
         quo_in = {quo_ff[NUM_W-2:0], 1'b1};
      end else begin
         rem_in = shifted[REFILL_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], 1'b0};
      end
   end

   // result staging and divider registers
   always_ff @(posedge clock) begin
      if (cmd.grant_apply) begin
         res_granted_ff <= 1'b1;
         res_level_ff   <= cur_level - ONE[LEVEL_W-1:0];
      end else if (cmd.div_start) begin
         res_granted_ff <= 1'b0;
         res_level_ff   <= cur_level;
         rem_ff         <= '0;
         quo_ff         <= numerator[NUM_W-1:0];
         div_ff         <= refill_ff[cls_idx];
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // round up, saturate, zero refill means never
   always_comb begin
      wait_full = 32'(quo_ff) + 32'(rem_ff != '0);
      if (res_granted_ff)
         out_wait_in = '0;
      else if (div_ff == '0 || wait_full > 32'(WAIT_MAX))
         out_wait_in = WAIT_MAX;
      else
         out_wait_in = wait_full[WAIT_W-1:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_granted_ff <= res_granted_ff;
         out_wait_ff    <= out_wait_in;
         out_level_ff   <= res_level_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_granted_ff;
   assign rsp_tdata  = {(RSP_DATA_W - WAIT_W - LEVEL_W)'(0), out_level_ff, out_wait_ff};

endmodule

// File: rtl/tcbl_checker.sv
`timescale 1ns / 1ps
// port-level assertions for the token bucket limiter, bound to the top level
module tcbl_checker #(
   parameter int FRACTION_BITS = tcbl_pkg::FRACTION_BITS_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic                            rsp_tuser,
   input logic [tcbl_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tcbl_pkg::*;

   logic [WAIT_W-1:0]  rsp_wait;
   logic [LEVEL_W-1:0] rsp_level;

   assign rsp_wait  = rsp_tdata[WAIT_W-1:0];
   assign rsp_level = rsp_tdata[WAIT_W+LEVEL_W-1:WAIT_W];

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // a grant reports no wait
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_wait == '0)
      else $error("granted result with nonzero wait");

   // a refusal reports a level below one token and a nonzero wait
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         (32'(rsp_level) < (32'd1 << FRACTION_BITS)) && (rsp_wait != '0))
      else $error("refused result inconsistent with its level");

   // one beat at a time: no back-to-back acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous beat in work");

endmodule

bind three_class_token_bucket_limiter_core tcbl_checker #(
   .FRACTION_BITS(FRACTION_BITS)
) u_tcbl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

// File: test/testbench.sv
`timescale 1ns / 1ps
// testbench for the three-class token bucket limiter core, checked against a local bucket model
module testbench;
   import tcbl_pkg::*;

   localparam int FRACTION_BITS   = FRACTION_BITS_DEFAULT;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int SETTLE_CYCLES   = 40;
   localparam int QUIET_LIMIT     = 5000;
   localparam int DIRECTED_ROWS   = 11;

   // traffic classes as carried in req_tdata
   localparam logic [CLASS_W-1:0] CLASS_ORDER   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_QUERY   = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_PUBLIC  = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 2'd3;

   // register indexes past the end of the map, writes there are dropped
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic              granted;
      logic [WAIT_W-1:0] wait_ticks;
      logic [LEVEL_W-1:0] level_after;
   } bucket_result_type;

   typedef struct packed {
      logic               action;
      logic [CLASS_W-1:0] cls;
      logic [4:0]         reps;
      logic               typed;
      bucket_result_type  want;
   } directed_row_type;

   localparam bucket_result_type NO_RESULT = '0;

   // directed stimulus under the reset limits; typed rows carry the answer
   localparam directed_row_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      '{ACTION_REQUEST, CLASS_ORDER,   5'd1, 1'b1, '{1'b1, 17'd0, 24'h090000}},
      '{ACTION_REQUEST, CLASS_QUERY,   5'd1, 1'b1, '{1'b1, 17'd0, 24'h130000}},
      '{ACTION_REQUEST, CLASS_PUBLIC,  5'd1, 1'b1, '{1'b1, 17'd0, 24'h130000}},
      '{ACTION_REQUEST, CLASS_UNKNOWN, 5'd1, 1'b0, NO_RESULT},
      '{ACTION_TICK,    CLASS_ORDER,   5'd1, 1'b0, NO_RESULT},
      '{ACTION_TICK,    CLASS_UNKNOWN, 5'd1, 1'b0, NO_RESULT},
      '{ACTION_REQUEST, CLASS_ORDER,   5'd9, 1'b0, NO_RESULT},
      '{ACTION_REQUEST, CLASS_ORDER,   5'd1, 1'b0, NO_RESULT},
      '{ACTION_REQUEST, CLASS_UNKNOWN, 5'd1, 1'b0, NO_RESULT},
      '{ACTION_TICK,    CLASS_QUERY,   5'd2, 1'b0, NO_RESULT},
      '{ACTION_REQUEST, CLASS_PUBLIC,  5'd2, 1'b0, NO_RESULT}
   };

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic                    req_tuser  = ACTION_TICK;  // [0] action
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;           // [1:0] traffic_class
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b1;
   logic                    rsp_tuser;                  // [0] granted
   logic [RSP_DATA_W-1:0]   rsp_tdata;                  // [16:0] wait_ticks, [40:17] level_after
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   // bucket model state and mirrored limits
   logic [LEVEL_W-1:0]  bucket_level [REG_CLASSES];
   logic [CAP_W-1:0]    limit_cap    [REG_CLASSES];
   logic [REFILL_W-1:0] limit_refill [REG_CLASSES];

   bucket_result_type pending_results [$];
   int mismatch_count = 0;
   int idle_odds      = 0;

   three_class_token_bucket_limiter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // full level of one bucket, clipped to the level width
   function automatic logic [LEVEL_W-1:0] bucket_ceiling(input int cls);
      logic [63:0] top;
      top = 64'(limit_cap[cls]) << FRACTION_BITS;
      return (top > 64'(LEVEL_MAX)) ? LEVEL_MAX : top[LEVEL_W-1:0];
   endfunction

   // apply one beat to the bucket model, returns 1 when a result is due
   function automatic bit advance_buckets(input logic act, input logic [CLASS_W-1:0] cls,
                                          output bucket_result_type res);
      logic [63:0] unit;
      logic [63:0] lvl;
      logic [63:0] rate;
      logic [63:0] sum;
      logic [63:0] top;
      logic [63:0] waited;
      unit = 64'd1 << FRACTION_BITS;
      res  = '0;
      // tick: refill all buckets, clamp at capacity
      if (act == ACTION_TICK) begin
         for (int i = 0; i < REG_CLASSES; i++) begin
            sum = 64'(bucket_level[i]) + 64'(limit_refill[i]);
            top = 64'(bucket_ceiling(i));
            bucket_level[i] = (sum > top) ? top[LEVEL_W-1:0] : sum[LEVEL_W-1:0];
         end
         return 1'b0;
      end
      // class outside the bucket set is dropped
      if (cls >= REG_CLASSES || cls >= NUM_CLASSES) return 1'b0;
      lvl = 64'(bucket_level[cls]);
      if (lvl >= unit) begin
         lvl = lvl - unit;
         bucket_level[cls] = lvl[LEVEL_W-1:0];
         res.granted     = 1'b1;
         res.wait_ticks  = '0;
         res.level_after = lvl[LEVEL_W-1:0];
      end else begin
         rate = 64'(limit_refill[cls]);
         // zero refill means never
         if (rate == 0) begin
            waited = 64'(WAIT_MAX);
         end else begin
            waited = (unit - lvl + rate - 1) / rate;
            if (waited > 64'(WAIT_MAX)) waited = 64'(WAIT_MAX);
         end
         res.granted     = 1'b0;
         res.wait_ticks  = waited[WAIT_W-1:0];
         res.level_after = lvl[LEVEL_W-1:0];
      end
      return 1'b1;
   endfunction

   // one register write; csr_valid is left high for a following write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx <= REG_PUBLIC_CAPACITY)
         limit_cap[idx] = val[CAP_W-1:0];
      else if (idx <= REG_PUBLIC_REFILL)
         limit_refill[idx - REG_ORDER_REFILL] = val[REFILL_W-1:0];
   endtask

   // load all six limits, capacity beats carry junk in the upper bits
   task automatic load_limits(input logic [2:0][CAP_W-1:0] caps,
                              input logic [2:0][REFILL_W-1:0] refills, input bit spares);
      logic [CSR_DATA_W-1:0] val;
      for (int i = 0; i < REG_CLASSES; i++) begin
         val = CSR_DATA_W'($urandom);
         val[CAP_W-1:0] = caps[i];
         write_reg(CSR_INDEX_W'(REG_ORDER_CAPACITY + i), val);
      end
      for (int i = 0; i < REG_CLASSES; i++)
         write_reg(CSR_INDEX_W'(REG_ORDER_REFILL + i), refills[i]);
      if (spares) begin
         write_reg(REG_SPARE_LO, CSR_DATA_W'($urandom));
         write_reg(REG_SPARE_HI, '1);
      end
      csr_valid <= 1'b0;
   endtask

   // push one request or tick beat, with an occasional gap in front
   task automatic send_beat(input logic act, input logic [CLASS_W-1:0] cls,
                            input bit typed, input bucket_result_type want);
      bucket_result_type res;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= REQ_DATA_W'(cls);
      do @(posedge clock); while (!req_tready);
      if (advance_buckets(act, cls, res))
         pending_results.push_back(typed ? want : res);
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // drain and let a dropped beat finish before touching the limits
   task automatic settle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random beats for one phase of limits
   task automatic run_items(input int count, input bit last_phase);
      int tick_pct;
      logic act;
      logic [CLASS_W-1:0] cls;
      tick_pct = $urandom_range(10, 50);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 3))
               0: idle_odds = 0;
               1: idle_odds = 2;
               2: idle_odds = 5;
               default: idle_odds = 10;
            endcase
            if (last_phase) idle_odds = 0;
         end
         // hold off the sender until every result is back
         if (n == count / 2) wait_results();
         if (n < 4) begin
            act = ACTION_REQUEST;
            cls = CLASS_W'($urandom_range(0, 2));
         end else if ($urandom_range(0, 99) < tick_pct) begin
            act = ACTION_TICK;
            cls = CLASS_W'($urandom_range(0, 3));
         end else begin
            act = ACTION_REQUEST;
            cls = ($urandom_range(0, 19) == 0) ? CLASS_UNKNOWN
                                               : CLASS_W'($urandom_range(0, 2));
         end
         send_beat(act, cls, 1'b0, NO_RESULT);
      end
   endtask

   // result side: random stall bursts
   initial begin
      forever begin
         @(posedge clock);
         if (idle_odds != 0 && $urandom_range(1, idle_odds * 3) == 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each result beat with the oldest expected one
   always @(posedge clock) begin : result_check
      bucket_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_results.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result beat: granted %0d wait %0d level %h",
                        rsp_tuser, rsp_tdata[WAIT_W-1:0], rsp_tdata[WAIT_W +: LEVEL_W]);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.granted || rsp_tdata[WAIT_W-1:0] !== want.wait_ticks ||
                rsp_tdata[WAIT_W +: LEVEL_W] !== want.level_after) begin
               if (mismatch_count < 10)
                  $display("result mismatch: granted %0d/%0d wait %0d/%0d level %h/%h (exp/got)",
                           want.granted, rsp_tuser, want.wait_ticks, rsp_tdata[WAIT_W-1:0],
                           want.level_after, rsp_tdata[WAIT_W +: LEVEL_W]);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // main sequence
   initial begin
      logic [2:0][CAP_W-1:0]    caps;
      logic [2:0][REFILL_W-1:0] refills;
      // limits and levels after reset: full buckets of 10, 20, 20 tokens
      limit_cap[0] = 8'd10;
      limit_cap[1] = 8'd20;
      limit_cap[2] = 8'd20;
      limit_refill[0] = 20'd655;
      limit_refill[1] = 20'd1311;
      limit_refill[2] = 20'd1311;
      for (int i = 0; i < REG_CLASSES; i++) bucket_level[i] = bucket_ceiling(i);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows under the reset limits
      idle_odds = 4;
      for (int r = 0; r < DIRECTED_ROWS; r++)
         for (int k = 0; k < DIRECTED_PLAN[r].reps; k++)
            send_beat(DIRECTED_PLAN[r].action, DIRECTED_PLAN[r].cls,
                      DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].want);

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         case (ph)
            // largest buckets and refills
            0: begin
               caps    = {3{8'd255}};
               refills = {3{20'hFFFFF}};
            end
            // smallest nonzero limits, lowers capacity below the levels left behind
            1: begin
               caps    = {3{8'd1}};
               refills = {3{20'd1}};
            end
            // zero capacity and zero refill on the order bucket
            2: begin
               caps    = {8'd3, 8'd7, 8'd0};
               refills = {20'd1, 20'd65536, 20'd0};
            end
            default: begin
               for (int i = 0; i < REG_CLASSES; i++) begin
                  case ($urandom_range(0, 11))
                     0: caps[i] = 8'd0;
                     1: caps[i] = 8'd255;
                     2: caps[i] = 8'd1;
                     3, 4, 5: caps[i] = CAP_W'($urandom_range(1, 255));
                     default: caps[i] = CAP_W'($urandom_range(1, 12));
                  endcase
                  case ($urandom_range(0, 19))
                     0: refills[i] = '0;
                     1: refills[i] = '1;
                     2: refills[i] = 20'd1;
                     default: refills[i] =
                        REFILL_W'($urandom_range(1, (1 << $urandom_range(1, 20)) - 1));
                  endcase
               end
            end
         endcase
         load_limits(caps, refills, ph == 0 || $urandom_range(0, 3) == 0);
         run_items(ITEMS_PER_PHASE, ph == PHASES - 1);
      end

      settle();
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
